// File: rtl/ccfi_pkg.sv
// Package for the call-chain fault injector core.
// Sizes, operation and register codes, entry layout and controller states.
// No dependencies.
`timescale 1ns / 1ps

package ccfi_pkg;

    localparam int PROCESS_SLOTS = 64;
    localparam int MAX_CHAIN     = 8;
    localparam int SLOT_W        = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int STK_W         = $clog2(MAX_CHAIN + 1);
    localparam int STK_DEPTH     = PROCESS_SLOTS << STK_W;
    localparam int STK_AW        = SLOT_W + STK_W;

    localparam logic [31:0] ALWAYS_PASS = 32'hFFFFFF00;

    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_EXIT  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] CFG_CHAIN_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LEVEL_ENABLE = 2'd1;
    localparam logic [1:0] CFG_PASS_THRESH  = 2'd2;
    localparam logic [1:0] CFG_ERROR_LIMIT  = 2'd3;

    typedef struct packed {
        logic [3:0]  chain_length;
        logic [8:0]  level_enable_mask;
        logic [31:0] pass_threshold;
        logic [31:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] process_id;
        logic [15:0] nesting_counter;
        logic [3:0]  matched_levels;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               slot_missing;
        logic signed [12:0] override_value;
        logic               override;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PROC,
        ST_UNWIND,
        ST_DONE
    } state_t;

endpackage

// File: rtl/call_chain_fault_injector_core.sv
// Call-chain fault injector: top level with configuration registers and RAMs.
// Depends on ccfi_pkg, ccfi_ram and ccfi_ctrl.
// Flow: a request decided without lookup goes from ST_IDLE to ST_DONE; otherwise ST_SCAN
// reads one entry a cycle, then ST_PROC (and ST_UNWIND on exits) or ST_DONE follows.
// ST_DONE registers the result once the output is free; one request is taken at a time.
// Reset: aresetn (synchronous, active low) clears registers, valid bits and the
// override count; no RAM clearing pass is needed.
`timescale 1ns / 1ps

module call_chain_fault_injector_core import ccfi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // process_id, probe_level, random_sample, error_code
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // override, override_value, slot_missing
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t   cfg_reg;
    entry_t ent_wr_data, ent_rd_data;
    logic   ent_wr_en, stk_wr_en;
    logic [SLOT_W-1:0] ent_wr_addr, ent_rd_addr;
    logic [STK_AW-1:0] stk_wr_addr, stk_rd_addr;
    logic [15:0]       stk_wr_data, stk_rd_data;
    res_t   res;

    // take configuration requests at any time; the user must write only while idle (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHAIN_LENGTH: cfg_reg.chain_length      <= cfg_data[3:0];
                CFG_LEVEL_ENABLE: cfg_reg.level_enable_mask <= cfg_data[8:0];
                CFG_PASS_THRESH:  cfg_reg.pass_threshold    <= cfg_data;
                default:          cfg_reg.error_limit       <= cfg_data;
            endcase
        end
    end

    // per-process entries: process id, nesting counter, matched levels
    ccfi_ram #(.WIDTH(ENTRY_W), .DEPTH(PROCESS_SLOTS)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // recorded call depths, one row of stack words per slot
    ccfi_ram #(.WIDTH(16), .DEPTH(STK_DEPTH)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    ccfi_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_op      (s_tuser),
        .req_pid     (s_tdata[31:0]),
        .req_level   (s_tdata[35:32]),
        .req_random  (s_tdata[67:36]),
        .req_error   (signed'(s_tdata[80:68])),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .ent_wr_en   (ent_wr_en),
        .ent_wr_addr (ent_wr_addr),
        .ent_wr_data (ent_wr_data),
        .ent_rd_addr (ent_rd_addr),
        .ent_rd_data (ent_rd_data),
        .stk_wr_en   (stk_wr_en),
        .stk_wr_addr (stk_wr_addr),
        .stk_wr_data (stk_wr_data),
        .stk_rd_addr (stk_rd_addr),
        .stk_rd_data (stk_rd_data)
    );

    assign m_tdata = {1'b0, res};

endmodule

// File: rtl/ccfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ccfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ccfi_ctrl.sv
// Request sequencer: table scan, allocation, read-modify-write of one entry.
// Depends on ccfi_pkg; drives the entry and depth-stack RAMs of the top level.
`timescale 1ns / 1ps

module ccfi_ctrl import ccfi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_op,
    input  logic [31:0]        req_pid,
    input  logic [3:0]         req_level,
    input  logic [31:0]        req_random,
    input  logic signed [12:0] req_error,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               ent_wr_en,
    output logic [SLOT_W-1:0]  ent_wr_addr,
    output entry_t             ent_wr_data,
    output logic [SLOT_W-1:0]  ent_rd_addr,
    input  entry_t             ent_rd_data,
    output logic               stk_wr_en,
    output logic [STK_AW-1:0]  stk_wr_addr,
    output logic [15:0]        stk_wr_data,
    output logic [STK_AW-1:0]  stk_rd_addr,
    input  logic [15:0]        stk_rd_data
);

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [31:0]         pid_reg, pid_next;
    logic [3:0]          level_reg, level_next;
    logic signed [12:0]  err_reg, err_next;
    logic [PROCESS_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W:0]     scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_idx_reg, free_idx_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    entry_t              ent_reg, ent_next;
    logic [31:0]         count_reg, count_next;
    res_t                pend_reg, pend_next;
    res_t                res_reg, res_next;
    logic                res_vld_reg, res_vld_next;

    logic signed [5:0]   len_s, lvl_s, cm_s;
    logic [15:0]         mask_ext;
    logic                lvl_en, en0, under_limit, out_free;
    logic [4:0]          idx5;
    logic [3:0]          cm;

    assign len_s       = signed'({2'b00, cfg.chain_length});
    assign mask_ext    = {7'd0, cfg.level_enable_mask};
    assign en0         = cfg.level_enable_mask[0];
    assign under_limit = count_reg < cfg.error_limit;
    assign out_free    = !res_vld_reg || res_ready;
    assign req_ready   = (state_reg == ST_IDLE);
    assign res_valid   = res_vld_reg;
    assign res         = res_reg;
    assign cm          = ent_reg.matched_levels;
    assign cm_s        = signed'({2'b00, cm});
    assign lvl_s       = signed'({2'b00, level_reg});
    assign lvl_en      = mask_ext[level_reg];
    assign idx5        = {1'b0, cm} + 5'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            res_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            res_vld_reg <= res_vld_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pid_reg        <= pid_next;
        level_reg      <= level_next;
        err_reg        <= err_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        ent_reg        <= ent_next;
        pend_reg       <= pend_next;
        res_reg        <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        level_next      = level_reg;
        err_next        = err_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        ent_next        = ent_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        res_vld_next    = res_vld_reg && !res_ready;
        ent_wr_en       = 1'b0;
        ent_wr_addr     = slot_reg;
        ent_wr_data     = ent_reg;
        ent_rd_addr     = scan_reg[SLOT_W-1:0];
        stk_wr_en       = 1'b0;
        stk_wr_addr     = {slot_reg, idx5[STK_W-1:0]};
        stk_wr_data     = ent_reg.nesting_counter;
        stk_rd_addr     = {slot_reg, cm[STK_W-1:0]};

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    op_next         = req_op;
                    pid_next        = req_pid;
                    level_next      = req_level;
                    err_next        = req_error;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    pend_next       = '0;
                    state_next      = ST_SCAN;
                    case (req_op)
                        OP_ENTRY: begin
                            // drop a sampled-out request on the outermost level
                            if (signed'({2'b00, req_level}) == len_s - 6'sd1
                                    && cfg.pass_threshold < ALWAYS_PASS
                                    && req_random > cfg.pass_threshold) begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_EXIT: begin
                        end
                        OP_CHECK: begin
                            if (req_error == '0) begin
                                state_next = ST_DONE;
                            end else if (cfg.chain_length == 4'd1 && en0 && under_limit) begin
                                count_next                = count_reg + 32'd1;
                                pend_next.override        = 1'b1;
                                pend_next.override_value  = req_error;
                                state_next                = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (scan_reg < (SLOT_W + 1)'(PROCESS_SLOTS)) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[SLOT_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                    if (!valid_reg[scan_reg[SLOT_W-1:0]] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_reg[SLOT_W-1:0];
                    end
                end
                if (cmp_vld_reg && valid_reg[cmp_idx_reg]
                        && ent_rd_data.process_id == pid_reg) begin
                    cmp_vld_next = 1'b0;
                    slot_next    = cmp_idx_reg;
                    ent_next     = ent_rd_data;
                    state_next   = ST_PROC;
                end else if (!cmp_vld_reg && scan_reg == (SLOT_W + 1)'(PROCESS_SLOTS)) begin
                    if (op_reg == OP_EXIT) begin
                        state_next = ST_DONE;
                    end else if (free_found_reg) begin
                        // allocate the lowest free slot with a cleared entry
                        slot_next                 = free_idx_reg;
                        valid_next[free_idx_reg]  = 1'b1;
                        ent_next.process_id       = pid_reg;
                        ent_next.nesting_counter  = '0;
                        ent_next.matched_levels   = '0;
                        state_next                = ST_PROC;
                    end else begin
                        pend_next.slot_missing = 1'b1;
                        state_next             = ST_DONE;
                    end
                end
            end

            ST_PROC: begin
                ent_wr_en  = 1'b1;
                state_next = ST_DONE;
                case (op_reg)
                    OP_ENTRY: begin
                        if (cm_s < len_s) begin
                            if (cm_s == len_s - lvl_s - 6'sd1 && lvl_en && len_s >= lvl_s) begin
                                stk_wr_en = (idx5 <= 5'(MAX_CHAIN));
                                ent_wr_data.matched_levels = idx5[3:0];
                            end
                            ent_wr_data.nesting_counter = ent_reg.nesting_counter + 16'd1;
                        end
                    end
                    OP_EXIT: begin
                        ent_wr_data.nesting_counter = ent_reg.nesting_counter - 16'd1;
                        ent_next.nesting_counter    = ent_reg.nesting_counter - 16'd1;
                        if (cm >= 4'd1 && cm <= cfg.chain_length && cm <= 4'(MAX_CHAIN)) begin
                            // hold the write until the recorded depth is back
                            ent_wr_en  = 1'b0;
                            state_next = ST_UNWIND;
                        end
                    end
                    default: begin
                        if (cm_s == len_s - 6'sd1 && en0 && under_limit) begin
                            count_next               = count_reg + 32'd1;
                            pend_next.override       = 1'b1;
                            pend_next.override_value = err_reg;
                        end
                    end
                endcase
            end

            ST_UNWIND: begin
                ent_wr_en = 1'b1;
                if (stk_rd_data == ent_reg.nesting_counter) begin
                    ent_wr_data.matched_levels = cm - 4'd1;
                end
                if (lvl_s == len_s - 6'sd1) begin
                    valid_next[slot_reg] = 1'b0;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    res_next     = pend_reg;
                    res_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
